[rtl/core/uehr_pkg.sv]
// Shared constants, types and functions of the UDP echo header rewriter.
package uehr_pkg;

   localparam int MAX_PACKET = 2048;
   localparam int STORE_DEPTH = 17;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
   localparam int IDX_W = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int HDR_EXTRA_WORDS = 2;
   localparam int UDP_HDR_BYTES = 8;
   localparam int WORD_BYTES = 4;
   localparam int MIN_PACKET = 28;
   localparam int MIN_IHL = 5;
   localparam int TTL_WORD_INDEX = 2;
   localparam int SRC_WORD_INDEX = 3;
   localparam int DST_WORD_INDEX = 4;
   localparam logic [7:0] TTL_RESET = 8'd64;

   typedef enum logic {
      CMD_PASS,
      CMD_HEADER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0] word;
      logic [2:0] nbytes;
      logic last;
      logic [3:0] ihl;
      logic [15:0] csum;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } back_state_type;

   function automatic logic [15:0] fold16(input logic [19:0] s);
      logic [16:0] s1;
      s1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      return s1[15:0] + {15'd0, s1[16]};
   endfunction

endpackage

[rtl/core/uehr_if.sv]
// Valid/ready channel interfaces for packet words in and reply words out.
interface uehr_req_if;
   logic valid;
   logic ready;
   logic [31:0] in_word;
   logic [15:0] pkt_len;
   modport source(output valid, output in_word, output pkt_len, input ready);
   modport sink(input valid, input in_word, input pkt_len, output ready);
endinterface

interface uehr_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] out_word;
   logic [2:0] out_bytes;
   logic out_last;
   modport source(output valid, output out_word, output out_bytes, output out_last,
                  input ready);
   modport sink(input valid, input out_word, input out_bytes, input out_last,
                output ready);
endinterface

[rtl/core/udp_echo_header_rewriter.sv]
// UDP echo header rewriter top level: swaps IPv4/UDP addressing and rebuilds the header.
// Packet words are accepted at one per cycle unless the input stalls. Header words
// (IHL + 2 of them) go into a 17-entry header store while a running ones-complement sum
// is kept. When the command for the last header word reaches the queue head, the back
// end reads the store through its registered read port and loads the first rewritten
// word into the output register. The rest of the header follows at one word per cycle
// while the output is not stalled. A payload word is loaded into the output register
// when its command reaches the head of the queue and the output register can take it.
// The first word of every packet waits until the previous header burst has left the
// store, and the input also stalls while the command queue is full. After that first
// word, dropped packets are consumed at one word per cycle, queue permitting, with no reply word.
module udp_echo_header_rewriter #(
   parameter int QUEUE_DEPTH = uehr_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   uehr_req_if.sink req_chan,
   uehr_rsp_if.source rsp_chan,
   input logic csr_write,
   input logic [7:0] csr_wdata
);
   import uehr_pkg::*;

   logic [7:0] reply_ttl_ff, reply_ttl_in;
   logic push;
   cmd_type push_data;
   logic q_full;
   logic pop;
   cmd_type head;
   logic q_empty;
   logic ram_wr_en;
   logic [STORE_ADDR_W-1:0] ram_wr_addr;
   logic [31:0] ram_wr_data;
   logic ram_rd_en;
   logic [STORE_ADDR_W-1:0] ram_rd_addr;
   logic [31:0] ram_rd_data;
   logic hdr_done;

   assign reply_ttl_in = csr_write ? csr_wdata : reply_ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_ttl_ff <= TTL_RESET;
      end else begin
         reply_ttl_ff <= reply_ttl_in;
      end
   end

   uehr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .push(push),
      .push_data(push_data),
      .q_full(q_full),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .hdr_done(hdr_done)
   );

   uehr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(q_full),
      .pop(pop),
      .head(head),
      .empty(q_empty)
   );

   uehr_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   uehr_back u_back (
      .clock(clock),
      .reset(reset),
      .ttl(reply_ttl_ff),
      .head(head),
      .q_empty(q_empty),
      .pop(pop),
      .ram_rd_en(ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .hdr_done(hdr_done),
      .rsp_chan(rsp_chan)
   );
endmodule

[rtl/core/uehr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module uehr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 17,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input logic clock,
   input logic wr_en,
   input logic [ADDR_W-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/uehr_fifo.sv]
// Short command queue between the packet front end and the reply back end.
module uehr_fifo #(
   parameter int DEPTH = uehr_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input logic clock,
   input logic reset,
   input logic push,
   input uehr_pkg::cmd_type push_data,
   output logic full,
   input logic pop,
   output uehr_pkg::cmd_type head,
   output logic empty
);
   import uehr_pkg::*;

   cmd_type q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[rtl/core/uehr_front.sv]
// Front end: accepts packet words, checks the packet, buffers and sums the header.
module uehr_front (
   input logic clock,
   input logic reset,
   uehr_req_if.sink req_chan,
   output logic push,
   output uehr_pkg::cmd_type push_data,
   input logic q_full,
   output logic ram_wr_en,
   output logic [uehr_pkg::STORE_ADDR_W-1:0] ram_wr_addr,
   output logic [31:0] ram_wr_data,
   input logic hdr_done
);
   import uehr_pkg::*;

   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [3:0] header_words_ff, header_words_in;
   logic [IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [15:0] checksum_ff, checksum_in;
   logic dropping_ff, dropping_in;
   logic busy_ff, busy_in;

   logic accept;
   logic start;
   logic header_phase;
   logic [15:0] len;
   logic [3:0] ihl;
   logic [15:0] hdr_min;
   logic drop;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] total;
   logic [15:0] acc;
   logic [15:0] acc_next;
   logic [19:0] sum;
   logic [2:0] take;
   logic [15:0] left_next;
   logic in_hdr;
   logic hdr_final;
   logic [31:0] w;

   always_comb begin
      w = req_chan.in_word;
      start = (bytes_left_ff == '0);
      header_phase = start || (!dropping_ff &&
         (hdr_idx_ff < ({1'b0, header_words_ff} + IDX_W'(HDR_EXTRA_WORDS))));
      req_chan.ready = !q_full && !(busy_ff && header_phase);
      accept = req_chan.valid && req_chan.ready;

      len = start ? req_chan.pkt_len : bytes_left_ff;
      ihl = start ? w[27:24] : header_words_ff;
      hdr_min = {10'd0, ihl, 2'b00} + 16'(UDP_HDR_BYTES);
      drop = start ? ((len < 16'(MIN_PACKET)) || (len > 16'(MAX_PACKET)) ||
                      (ihl < 4'(MIN_IHL)) || (len < hdr_min))
                   : dropping_ff;
      idx = start ? '0 : hdr_idx_ff;
      acc = start ? '0 : checksum_ff;
      total = {1'b0, ihl} + IDX_W'(HDR_EXTRA_WORDS);
      take = (len < 16'(WORD_BYTES)) ? len[2:0] : 3'(WORD_BYTES);
      left_next = len - {13'd0, take};
      in_hdr = (idx < total);
      hdr_final = in_hdr && ((idx + 1'b1) == total);

      if (idx == IDX_W'(TTL_WORD_INDEX)) begin
         sum = {4'd0, acc} + {12'd0, w[23:16]};
      end else begin
         sum = {4'd0, acc} + {4'd0, w[31:16]} + {4'd0, w[15:0]};
      end
      acc_next = (idx < {1'b0, ihl}) ? fold16(sum) : acc;

      push = accept && !drop && (!in_hdr || hdr_final);
      push_data.kind = in_hdr ? CMD_HEADER : CMD_PASS;
      push_data.word = w;
      push_data.nbytes = take;
      push_data.last = (left_next == '0);
      push_data.ihl = ihl;
      push_data.csum = acc_next;

      ram_wr_en = accept && !drop && in_hdr;
      ram_wr_addr = idx[STORE_ADDR_W-1:0];
      ram_wr_data = w;
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      header_words_in = header_words_ff;
      hdr_idx_in = hdr_idx_ff;
      checksum_in = checksum_ff;
      dropping_in = dropping_ff;
      busy_in = busy_ff;
      if (accept) begin
         bytes_left_in = left_next;
         header_words_in = ihl;
         dropping_in = drop;
         checksum_in = acc_next;
         hdr_idx_in = in_hdr ? idx + 1'b1 : idx;
      end
      if (push && hdr_final) begin
         busy_in = 1'b1;
      end else if (hdr_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         header_words_ff <= '0;
         hdr_idx_ff <= '0;
         checksum_ff <= '0;
         dropping_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         header_words_ff <= header_words_in;
         hdr_idx_ff <= hdr_idx_in;
         checksum_ff <= checksum_in;
         dropping_ff <= dropping_in;
         busy_ff <= busy_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_write_during_burst: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !busy_ff)
      else $error("header store written while a header burst is pending");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into a full queue");
   a_burst_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.kind == CMD_HEADER) |=> busy_ff)
      else $error("header burst queued without marking the store busy");
`endif
endmodule

[rtl/core/uehr_back.sv]
// Back end: rewrites buffered header words and drives the reply output register.
module uehr_back (
   input logic clock,
   input logic reset,
   input logic [7:0] ttl,
   input uehr_pkg::cmd_type head,
   input logic q_empty,
   output logic pop,
   output logic ram_rd_en,
   output logic [uehr_pkg::STORE_ADDR_W-1:0] ram_rd_addr,
   input logic [31:0] ram_rd_data,
   output logic hdr_done,
   uehr_rsp_if.source rsp_chan
);
   import uehr_pkg::*;

   back_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [3:0] ihl_ff, ihl_in;
   logic [15:0] csum_ff, csum_in;
   logic last_ff, last_in;
   logic out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff;
   logic [2:0] out_bytes_ff;
   logic out_last_ff;

   logic can_load;
   logic load;
   logic [31:0] load_word;
   logic [2:0] load_bytes;
   logic load_last;
   logic [IDX_W-1:0] total;
   logic final_word;
   logic [16:0] ttl_sum;
   logic [15:0] cs;
   logic [31:0] hdr_word;

   function automatic logic [STORE_ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] a;
      if (i == IDX_W'(SRC_WORD_INDEX)) begin
         a = IDX_W'(DST_WORD_INDEX);
      end else if (i == IDX_W'(DST_WORD_INDEX)) begin
         a = IDX_W'(SRC_WORD_INDEX);
      end else begin
         a = i;
      end
      return a[STORE_ADDR_W-1:0];
   endfunction

   always_comb begin
      can_load = !out_valid_ff || rsp_chan.ready;
      total = {1'b0, ihl_ff} + IDX_W'(HDR_EXTRA_WORDS);
      final_word = (idx_ff == total - 1'b1);
      ttl_sum = {1'b0, csum_ff} + {1'b0, ttl, 8'h00};
      cs = ~fold16({3'd0, ttl_sum});
      if (idx_ff == IDX_W'(TTL_WORD_INDEX)) begin
         hdr_word = {ttl, ram_rd_data[23:16], cs};
      end else if (idx_ff == {1'b0, ihl_ff}) begin
         hdr_word = {ram_rd_data[15:0], ram_rd_data[31:16]};
      end else if (idx_ff == {1'b0, ihl_ff} + 1'b1) begin
         hdr_word = {ram_rd_data[31:16], 16'h0000};
      end else begin
         hdr_word = ram_rd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && head.kind == CMD_HEADER) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (can_load && final_word) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop = 1'b0;
      ram_rd_en = 1'b0;
      ram_rd_addr = store_addr(idx_ff);
      load = 1'b0;
      load_word = head.word;
      load_bytes = head.nbytes;
      load_last = head.last;
      hdr_done = 1'b0;
      idx_in = idx_ff;
      ihl_in = ihl_ff;
      csum_in = csum_ff;
      last_in = last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (head.kind == CMD_HEADER) begin
                  pop = 1'b1;
                  ihl_in = head.ihl;
                  csum_in = head.csum;
                  last_in = head.last;
                  idx_in = '0;
                  ram_rd_en = 1'b1;
                  ram_rd_addr = store_addr('0);
               end else if (can_load) begin
                  pop = 1'b1;
                  load = 1'b1;
               end
            end
         end
         BK_EMIT: begin
            load_word = hdr_word;
            load_bytes = 3'(WORD_BYTES);
            load_last = final_word && last_ff;
            if (can_load) begin
               load = 1'b1;
               if (final_word) begin
                  hdr_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  ram_rd_en = 1'b1;
                  ram_rd_addr = store_addr(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      out_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ihl_ff <= ihl_in;
      csum_ff <= csum_in;
      last_ff <= last_in;
      if (load) begin
         out_word_ff <= load_word;
         out_bytes_ff <= load_bytes;
         out_last_ff <= load_last;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_word = out_word_ff;
   assign rsp_chan.out_bytes = out_bytes_ff;
   assign rsp_chan.out_last = out_last_ff;

`ifndef NO_ASSERTIONS
   a_emit_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EMIT) |-> (idx_ff < total))
      else $error("header emit index past the buffered header");
   a_done_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      hdr_done |-> (state_ff == BK_EMIT && load))
      else $error("header burst finished outside the emit state");
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("command popped from an empty queue");
`endif
endmodule
